// ===== hw/rtl/afk_pkg.sv =====
package afk_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int IN_W           = 16;
   localparam int REG_W          = 18;
   localparam int OUT_W          = 20;
   localparam int NUM_REGS       = 8;
   localparam int IDX_W          = 3;
   localparam int CORDIC_STEPS   = 28;
   localparam int CW             = 34;   // CORDIC datapath width (Q30 plus headroom)
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_L0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_D1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_L1 = 3'd2;
   localparam logic [IDX_W-1:0] REG_D2 = 3'd3;
   localparam logic [IDX_W-1:0] REG_L2 = 3'd4;
   localparam logic [IDX_W-1:0] REG_D3 = 3'd5;
   localparam logic [IDX_W-1:0] REG_D4 = 3'd6;
   localparam logic [IDX_W-1:0] REG_L3 = 3'd7;

   typedef struct packed {
      logic signed [IN_W-1:0] base_yaw;
      logic signed [IN_W-1:0] shoulder_pitch;
      logic signed [IN_W-1:0] elbow_pitch;
      logic signed [IN_W-1:0] wrist_pitch;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pos_x;
      logic signed [OUT_W-1:0] pos_y;
      logic signed [OUT_W-1:0] pos_z;
   } rsp_type;

   typedef struct packed {
      logic signed [REG_W-1:0] l0;
      logic signed [REG_W-1:0] d1;
      logic signed [REG_W-1:0] l1;
      logic signed [REG_W-1:0] d2;
      logic signed [REG_W-1:0] l2;
      logic signed [REG_W-1:0] d3;
      logic signed [REG_W-1:0] d4;
      logic signed [REG_W-1:0] l3;
   } geom_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic signed [CW-1:0] atan_lut(input int i);
      logic signed [CW-1:0] v;
      case (i)
         0: v = 34'sd536870912;   1: v = 34'sd316933406;
         2: v = 34'sd167458907;   3: v = 34'sd85004756;
         4: v = 34'sd42667331;    5: v = 34'sd21354465;
         6: v = 34'sd10679838;    7: v = 34'sd5340245;
         8: v = 34'sd2670163;     9: v = 34'sd1335087;
         10: v = 34'sd667544;     11: v = 34'sd333772;
         12: v = 34'sd166886;     13: v = 34'sd83443;
         14: v = 34'sd41721;      15: v = 34'sd20860;
         16: v = 34'sd10430;      17: v = 34'sd5215;
         18: v = 34'sd2607;       19: v = 34'sd1303;
         20: v = 34'sd651;        21: v = 34'sd325;
         22: v = 34'sd162;        23: v = 34'sd81;
         24: v = 34'sd40;         25: v = 34'sd20;
         26: v = 34'sd10;         27: v = 34'sd5;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/afk_cordic.sv =====
// Pipelined sine/cosine: quadrant fold, then one CORDIC rotation per stage.
// Four angles travel side by side in lanes; the stall freezes every stage.
module afk_cordic #(
   parameter int FRAC_BITS = afk_pkg::FRAC_BITS_DEF,
   parameter int LANES     = 4,
   parameter int TW        = FRAC_BITS + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [LANES-1:0][31:0]      in_angle,
   output logic                        out_valid,
   output logic signed [LANES-1:0][TW-1:0] out_cos,
   output logic signed [LANES-1:0][TW-1:0] out_sin
);

   localparam int N  = afk_pkg::CORDIC_STEPS;
   localparam int CW = afk_pkg::CW;
   localparam int SH = 30 - FRAC_BITS;

   logic signed [CW-1:0] x_ff [N+1][LANES];
   logic signed [CW-1:0] y_ff [N+1][LANES];
   logic signed [CW-1:0] z_ff [N+1][LANES];
   logic        [1:0]    q_ff [N+1][LANES];
   logic                 v_ff [N+2];
   logic signed [TW-1:0] c_ff [LANES];
   logic signed [TW-1:0] s_ff [LANES];

   // Valid bits for the fold stage, every rotation and the rounding stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N + 2; k++) v_ff[k] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < N + 2; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // Quadrant fold to a residual within plus or minus one eighth turn.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            logic [1:0]  q;
            logic [31:0] res;
            q   = 2'(in_angle[l][31:30] + {1'b0, in_angle[l][29]});
            res = in_angle[l] - {q, 30'd0};
            q_ff[0][l] <= q;
            x_ff[0][l] <= afk_pkg::CORDIC_GAIN;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= CW'($signed(res));
         end
      end
   end

   // Rotation stages.
   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int l = 0; l < LANES; l++) begin
               q_ff[i+1][l] <= q_ff[i][l];
               if (!z_ff[i][l][CW-1]) begin
                  x_ff[i+1][l] <= x_ff[i][l] - (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] + (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] - afk_pkg::atan_lut(i);
               end else begin
                  x_ff[i+1][l] <= x_ff[i][l] + (y_ff[i][l] >>> i);
                  y_ff[i+1][l] <= y_ff[i][l] - (x_ff[i][l] >>> i);
                  z_ff[i+1][l] <= z_ff[i][l] + afk_pkg::atan_lut(i);
               end
            end
         end
      end
   end

   // Round half up to Q.FRAC_BITS and unfold the quadrant.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            logic signed [CW-1:0] cr;
            logic signed [CW-1:0] sr;
            logic signed [TW-1:0] c;
            logic signed [TW-1:0] s;
            cr = (x_ff[N][l] + (CW'(1) <<< SH) / 2 * 1) >>> SH;
            sr = (y_ff[N][l] + (CW'(1) <<< SH) / 2 * 1) >>> SH;
            c  = TW'(cr);
            s  = TW'(sr);
            case (q_ff[N][l])
               2'd0: begin c_ff[l] <= c;  s_ff[l] <= s;  end
               2'd1: begin c_ff[l] <= -s; s_ff[l] <= c;  end
               2'd2: begin c_ff[l] <= -c; s_ff[l] <= -s; end
               default: begin c_ff[l] <= s; s_ff[l] <= -c; end
            endcase
         end
      end
   end

   assign out_valid = v_ff[N+1];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_cos[l] = c_ff[l];
         out_sin[l] = s_ff[l];
      end
   end

endmodule

// ===== hw/rtl/arm_forward_kinematics_top.sv =====
// Forward kinematics of a four-joint arm: one pose request per cycle in while
// not stalled, one saturated end point out, through the quadrant fold, 28
// CORDIC rotation stages and the trig rounding stage, then the pitch-plane
// products, the reach and height rounding, the base rotation products and the
// final round and saturate stage. The whole pipeline halts while rsp_stall is
// high, so req_stall follows rsp_stall whenever the pipeline holds an item at
// its output. Geometry registers are written through the csr_ port; the user
// must write them only while no request is in flight (the block does not enforce it).
module arm_forward_kinematics_top #(
   parameter int ANGLE_BITS = afk_pkg::ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = afk_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  afk_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output afk_pkg::rsp_type         rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [afk_pkg::IDX_W-1:0] csr_index,
   input  logic [afk_pkg::REG_W-1:0] csr_wdata
);

   localparam int RW = afk_pkg::REG_W;
   localparam int OW = afk_pkg::OUT_W;
   localparam int TW = FRAC_BITS + 2;
   localparam int PW = RW + TW;          // length times trig value
   localparam int SW = PW + 3;           // sum of four products
   localparam int RRW = SW - FRAC_BITS + 1;
   localparam int XW = RRW + TW + 2;

   afk_pkg::geom_type geom_ff;
   logic advance;

   // Whole pipeline moves unless a finished result is held back.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Geometry registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.l0 <= 18'sd16384;
         geom_ff.d1 <= -18'sd2621;
         geom_ff.l1 <= 18'sd13107;
         geom_ff.d2 <= 18'sd2621;
         geom_ff.l2 <= 18'sd13107;
         geom_ff.d3 <= -18'sd2621;
         geom_ff.d4 <= -18'sd2621;
         geom_ff.l3 <= 18'sd9830;
      end else if (csr_valid) begin
         unique case (csr_index)
            afk_pkg::REG_L0: geom_ff.l0 <= csr_wdata;
            afk_pkg::REG_D1: geom_ff.d1 <= csr_wdata;
            afk_pkg::REG_L1: geom_ff.l1 <= csr_wdata;
            afk_pkg::REG_D2: geom_ff.d2 <= csr_wdata;
            afk_pkg::REG_L2: geom_ff.l2 <= csr_wdata;
            afk_pkg::REG_D3: geom_ff.d3 <= csr_wdata;
            afk_pkg::REG_D4: geom_ff.d4 <= csr_wdata;
            afk_pkg::REG_L3: geom_ff.l3 <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Keep the low ANGLE_BITS bits of a field and scale them to a full turn.
   function automatic logic [31:0] widen(input logic [afk_pkg::IN_W-1:0] raw);
      logic [63:0] m;
      m = (64'd1 << ANGLE_BITS) - 64'd1;
      return 32'((64'(raw) & m) << (32 - ANGLE_BITS));
   endfunction

   // Widen angles to 32-bit binary angles and form the joint sums.
   logic [3:0][31:0] ang_in;
   always_comb begin
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      w1 = widen(req_data.shoulder_pitch);
      w2 = widen(req_data.elbow_pitch);
      w3 = widen(req_data.wrist_pitch);
      ang_in[0] = widen(req_data.base_yaw);
      ang_in[1] = w1;
      ang_in[2] = w1 + w2;
      ang_in[3] = w1 + w2 + w3;
   end

   logic                           cs_valid;
   logic signed [3:0][TW-1:0]      cs_cos;
   logic signed [3:0][TW-1:0]      cs_sin;

   afk_cordic #(.FRAC_BITS(FRAC_BITS), .LANES(4), .TW(TW)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_angle  (ang_in),
      .out_valid (cs_valid),
      .out_cos   (cs_cos),
      .out_sin   (cs_sin)
   );

   // Stage A: the eight pitch-plane products.
   logic signed [PW-1:0] pr_ff [4];
   logic signed [PW-1:0] pz_ff [4];
   logic signed [TW-1:0] c0_ff, s0_ff;
   logic signed [RW+1:0] sd_ff;
   logic                 va_ff, vb_ff, vc_ff, vd_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         pr_ff[0] <= geom_ff.l1 * $signed(cs_cos[1]);
         pr_ff[1] <= geom_ff.l2 * $signed(cs_cos[2]);
         pr_ff[2] <= geom_ff.l3 * $signed(cs_cos[3]);
         pr_ff[3] <= geom_ff.d4 * $signed(cs_sin[3]);
         pz_ff[0] <= geom_ff.l1 * $signed(cs_sin[1]);
         pz_ff[1] <= geom_ff.l2 * $signed(cs_sin[2]);
         pz_ff[2] <= geom_ff.l3 * $signed(cs_sin[3]);
         pz_ff[3] <= geom_ff.d4 * $signed(cs_cos[3]);
         c0_ff    <= cs_cos[0];
         s0_ff    <= cs_sin[0];
         sd_ff    <= (RW+2)'(geom_ff.d1) + (RW+2)'(geom_ff.d2) + (RW+2)'(geom_ff.d3);
      end
   end

   // Stage B: round the reach and the height.
   logic signed [RRW-1:0] r_ff;
   logic signed [RRW:0]   z_ff;
   logic signed [TW-1:0]  c0b_ff, s0b_ff;
   logic signed [RW+1:0]  sdb_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         logic signed [SW-1:0] rs;
         logic signed [SW-1:0] zs;
         rs = SW'(pr_ff[0]) + SW'(pr_ff[1]) + SW'(pr_ff[2]) + SW'(pr_ff[3])
            + (SW'(1) <<< (FRAC_BITS - 1));
         zs = SW'(pz_ff[0]) + SW'(pz_ff[1]) + SW'(pz_ff[2]) - SW'(pz_ff[3])
            + (SW'(1) <<< (FRAC_BITS - 1));
         r_ff   <= RRW'(rs >>> FRAC_BITS);
         z_ff   <= (RRW+1)'(geom_ff.l0) - (RRW+1)'(zs >>> FRAC_BITS);
         c0b_ff <= c0_ff;
         s0b_ff <= s0_ff;
         sdb_ff <= sd_ff;
      end
   end

   // Stage C: base rotation products.
   logic signed [XW-1:0] rc_ff, rs_ff, sc_ff, ss_ff;
   logic signed [RRW:0]  zc_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         rc_ff <= XW'(r_ff) * XW'(c0b_ff);
         rs_ff <= XW'(r_ff) * XW'(s0b_ff);
         sc_ff <= XW'(sdb_ff) * XW'(c0b_ff);
         ss_ff <= XW'(sdb_ff) * XW'(s0b_ff);
         zc_ff <= z_ff;
      end
   end

   // Stage D: round and saturate the end point.
   function automatic logic signed [OW-1:0] sat(input logic signed [XW-1:0] v);
      if (v > XW'((1 <<< (OW - 1)) - 1)) return OW'((1 <<< (OW - 1)) - 1);
      if (v < -XW'(1 <<< (OW - 1))) return OW'(-(1 <<< (OW - 1)));
      return OW'(v);
   endfunction

   afk_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         logic signed [XW-1:0] xs;
         logic signed [XW-1:0] ys;
         xs = (rc_ff - ss_ff + (XW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         ys = (rs_ff + sc_ff + (XW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         out_ff.pos_x <= sat(xs);
         out_ff.pos_y <= sat(ys);
         out_ff.pos_z <= sat(XW'(zc_ff));
      end
   end

   // Valid bits alongside the product stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= cs_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   assign rsp_valid = vd_ff;
   assign rsp_data  = out_ff;

endmodule
